// ----- rtl/core/eia_pkg.sv -----
package eia_pkg;

    // Grid geometry
    localparam int SENSOR_SIDE = 128;
    localparam int PIX_COUNT   = SENSOR_SIDE * SENSOR_SIDE;
    localparam int ROW_W       = $clog2(SENSOR_SIDE);
    localparam int IDX_W       = $clog2(PIX_COUNT);

    // Field widths
    localparam int REQ_W   = 3;
    localparam int COORD_W = 7;
    localparam int STEP_W  = 7;
    localparam int PIX_W   = 8;
    localparam int TIME_W  = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 7'd127;

    // Saturation bounds of a pixel
    localparam logic signed [PIX_W:0] SAT_HIGH = 9'sd127;
    localparam logic signed [PIX_W:0] SAT_LOW  = -9'sd127;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_EVENT     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STAMP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLR_LEFT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RST_TIMES = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RST_LEFT  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RST_RIGHT = 3'd6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;       // latch the accepted item
        logic             clr_img_l;  // sweep writes zero into the image/time stores
        logic             clr_tim_l;
        logic             clr_img_r;
        logic             clr_tim_r;
        logic [IDX_W-1:0] clr_addr;
        logic             eval;       // evaluate the item and load the result
    } t_cmd;

endpackage

// ----- rtl/core/eia_ctrl.sv -----
module eia_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic [eia_pkg::REQ_W-1:0] i_req,
    input  logic                      i_eval_ok,
    output logic                      o_s_tready,
    output eia_pkg::t_cmd             o_cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;

    localparam logic [eia_pkg::IDX_W-1:0] LAST_IDX = eia_pkg::IDX_W'(eia_pkg::PIX_COUNT - 1);

    logic [2:0]                r_state, n_state;
    logic [eia_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic [3:0]                r_mask, n_mask;   // {tim_r, img_r, tim_l, img_l}
    logic [3:0]                req_mask;
    logic                      accept;

    assign accept     = (r_state == S_IDLE) && i_s_tvalid;
    assign o_s_tready = (r_state == S_IDLE);

    // Stores each clear request sweeps
    always_comb begin
        case (i_req)
            eia_pkg::REQ_CLR_LEFT:  req_mask = 4'b0011;
            eia_pkg::REQ_RST_TIMES: req_mask = 4'b1010;
            eia_pkg::REQ_RST_LEFT:  req_mask = 4'b0010;
            eia_pkg::REQ_RST_RIGHT: req_mask = 4'b1000;
            default:                req_mask = 4'b0000;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mask  = r_mask;
        case (r_state)
            S_INIT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_mask = req_mask;
                    n_cnt  = '0;
                    n_state = (req_mask != 4'b0000) ? S_CLEAR : S_READ;
                end
            end
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_eval_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = accept;
        o_cmd.clr_addr  = r_cnt;
        o_cmd.eval      = (r_state == S_EVAL);
        if (r_state == S_INIT) begin
            o_cmd.clr_img_l = 1'b1;
            o_cmd.clr_tim_l = 1'b1;
            o_cmd.clr_img_r = 1'b1;
            o_cmd.clr_tim_r = 1'b1;
        end else if (r_state == S_CLEAR) begin
            o_cmd.clr_img_l = r_mask[0];
            o_cmd.clr_tim_l = r_mask[1];
            o_cmd.clr_img_r = r_mask[2];
            o_cmd.clr_tim_r = r_mask[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_mask  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mask  <= n_mask;
        end
    end

endmodule

// ----- rtl/core/eia_dp.sv -----
module eia_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  eia_pkg::t_cmd              i_cmd,
    input  logic [3:0]                 i_s_tuser,
    input  logic [47:0]                i_s_tdata,
    input  logic                       i_cfg_wen,
    input  logic [eia_pkg::STEP_W-1:0] i_cfg_wdata,
    input  logic                       i_m_tready,
    output logic                       o_eval_ok,
    output logic                       o_m_tvalid,
    output logic [103:0]               o_m_tdata,
    output logic [1:0]                 o_m_tuser
);

    localparam int IW = eia_pkg::IDX_W;
    localparam int PW = eia_pkg::PIX_W;
    localparam int TW = eia_pkg::TIME_W;
    localparam int RW = eia_pkg::ROW_W;

    // Pixel stores, one read and one write port each
    logic [PW-1:0] img_l [eia_pkg::PIX_COUNT];
    logic [TW-1:0] tim_l [eia_pkg::PIX_COUNT];
    logic [PW-1:0] img_r [eia_pkg::PIX_COUNT];
    logic [TW-1:0] tim_r [eia_pkg::PIX_COUNT];
    logic [PW-1:0] r_rd_img_l, r_rd_img_r;
    logic [TW-1:0] r_rd_tim_l, r_rd_tim_r;

    // Latched item
    logic [eia_pkg::REQ_W-1:0] r_req;
    logic                      r_cam, r_pol, r_inside, r_rc_nz;
    logic [IW-1:0]             r_addr;
    logic [TW-1:0]             r_stamp;

    // Block state
    logic [eia_pkg::STEP_W-1:0] r_step;
    logic [TW-1:0]              r_cur, r_lat_l, r_lat_r;
    logic [1:0]                 r_seen;

    // Output register
    logic          r_out_valid;
    logic [PW-1:0] r_out_pix;
    logic [TW-1:0] r_out_time;
    logic [TW-1:0] r_out_lat_l, r_out_lat_r;
    logic [1:0]    r_out_seen;

    // Item decode from the input transfer
    logic [eia_pkg::COORD_W-1:0] in_a, in_b;
    logic [eia_pkg::REQ_W-1:0]   in_req;
    logic                        in_event, in_inside;
    logic [RW-1:0]               in_row, in_col;

    assign in_a      = i_s_tdata[6:0];
    assign in_b      = i_s_tdata[13:7];
    assign in_req    = i_s_tuser[2:0];
    assign in_event  = (in_req == eia_pkg::REQ_EVENT);
    assign in_inside = (32'(in_a) < 32'(eia_pkg::SENSOR_SIDE))
                     && (32'(in_b) < 32'(eia_pkg::SENSOR_SIDE));

    // Events address the flipped pixel
    always_comb begin
        if (in_event) begin
            in_row = RW'(eia_pkg::SENSOR_SIDE - 1) - RW'(in_a);
            in_col = RW'(eia_pkg::SENSOR_SIDE - 1) - RW'(in_b);
        end else begin
            in_row = RW'(in_a);
            in_col = RW'(in_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= in_req;
            r_cam    <= i_s_tuser[3];
            r_pol    <= i_s_tdata[14];
            r_inside <= in_inside;
            r_rc_nz  <= (in_row != '0) && (in_col != '0);
            r_addr   <= IW'(in_row) * IW'(eia_pkg::SENSOR_SIDE) + IW'(in_col);
            r_stamp  <= i_s_tdata[46:15];
        end
    end

    // Event evaluation on the registered read data
    logic [PW-1:0]           rd_img;
    logic [TW-1:0]           rd_tim;
    logic signed [PW:0]      sum;
    logic [PW-1:0]           new_img;
    logic                    is_event, upd, eval_fire;

    assign o_eval_ok = !r_out_valid || i_m_tready;
    assign eval_fire = i_cmd.eval && o_eval_ok;
    assign rd_img    = r_cam ? r_rd_img_l : r_rd_img_r;
    assign rd_tim    = r_cam ? r_rd_tim_l : r_rd_tim_r;
    assign is_event  = (r_req == eia_pkg::REQ_EVENT) && r_inside;
    assign upd       = is_event && (rd_tim < r_cur);

    always_comb begin
        if (r_pol) begin
            sum = $signed({rd_img[PW-1], rd_img}) + $signed({2'b00, r_step});
        end else begin
            sum = $signed({rd_img[PW-1], rd_img}) - $signed({2'b00, r_step});
        end
        if (sum > eia_pkg::SAT_HIGH) begin
            new_img = PW'(eia_pkg::SAT_HIGH);
        end else if (sum < eia_pkg::SAT_LOW) begin
            new_img = PW'(eia_pkg::SAT_LOW);
        end else begin
            new_img = sum[PW-1:0];
        end
    end

    // Store write ports: clearing sweep or event update
    logic          we_img_l, we_tim_l, we_img_r, we_tim_r;
    logic [IW-1:0] waddr_l, waddr_r;
    logic [PW-1:0] wimg_l, wimg_r;
    logic [TW-1:0] wtim_l, wtim_r;

    always_comb begin
        we_img_l = i_cmd.clr_img_l || (eval_fire && upd && r_cam);
        we_tim_l = i_cmd.clr_tim_l || (eval_fire && upd && r_cam);
        we_img_r = i_cmd.clr_img_r || (eval_fire && upd && !r_cam);
        we_tim_r = i_cmd.clr_tim_r || (eval_fire && upd && !r_cam);
        waddr_l  = (i_cmd.clr_img_l || i_cmd.clr_tim_l) ? i_cmd.clr_addr : r_addr;
        waddr_r  = (i_cmd.clr_img_r || i_cmd.clr_tim_r) ? i_cmd.clr_addr : r_addr;
        wimg_l   = i_cmd.clr_img_l ? '0 : new_img;
        wtim_l   = i_cmd.clr_tim_l ? '0 : r_cur;
        wimg_r   = i_cmd.clr_img_r ? '0 : new_img;
        wtim_r   = i_cmd.clr_tim_r ? '0 : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (we_img_l) begin
            img_l[waddr_l] <= wimg_l;
        end
        r_rd_img_l <= img_l[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_tim_l) begin
            tim_l[waddr_l] <= wtim_l;
        end
        r_rd_tim_l <= tim_l[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_img_r) begin
            img_r[waddr_r] <= wimg_r;
        end
        r_rd_img_r <= img_r[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_tim_r) begin
            tim_r[waddr_r] <= wtim_r;
        end
        r_rd_tim_r <= tim_r[r_addr];
    end

    // Next values of the stamps and flags after this item
    logic [TW-1:0] n_cur, n_lat_l, n_lat_r;
    logic [1:0]    n_seen;

    always_comb begin
        n_cur   = r_cur;
        n_lat_l = r_lat_l;
        n_lat_r = r_lat_r;
        n_seen  = r_seen;
        case (r_req)
            eia_pkg::REQ_EVENT: begin
                if (r_inside) begin
                    if (r_rc_nz && (r_cur != '0)) begin
                        if (r_cam) n_seen[0] = 1'b1;
                        else       n_seen[1] = 1'b1;
                    end
                    if (r_cam && (r_cur > r_lat_l)) n_lat_l = r_cur;
                    if (!r_cam && (r_cur > r_lat_r)) n_lat_r = r_cur;
                end
            end
            eia_pkg::REQ_STAMP: begin
                n_cur = r_stamp;
            end
            eia_pkg::REQ_RST_TIMES: begin
                n_lat_l = '0;
                n_lat_r = '0;
            end
            eia_pkg::REQ_RST_LEFT: begin
                n_lat_l = '0;
            end
            eia_pkg::REQ_RST_RIGHT: begin
                n_lat_r = '0;
            end
            default: begin
            end
        endcase
    end

    // Configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= eia_pkg::STEP_RESET;
            r_cur   <= '0;
            r_lat_l <= '0;
            r_lat_r <= '0;
            r_seen  <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_step <= i_cfg_wdata;
            end
            if (eval_fire) begin
                r_cur   <= n_cur;
                r_lat_l <= n_lat_l;
                r_lat_r <= n_lat_r;
                r_seen  <= n_seen;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_fire) begin
            if (!r_inside) begin
                r_out_pix  <= '0;
                r_out_time <= '0;
            end else if (upd) begin
                r_out_pix  <= new_img;
                r_out_time <= r_cur;
            end else begin
                r_out_pix  <= rd_img;
                r_out_time <= rd_tim;
            end
            r_out_lat_l <= n_lat_l;
            r_out_lat_r <= n_lat_r;
            r_out_seen  <= n_seen;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_lat_r, r_out_lat_l, r_out_time, r_out_pix};
    assign o_m_tuser  = r_out_seen;

endmodule

// ----- rtl/core/event_image_accumulator_core.sv -----
// Event image accumulator for a left and a right event camera.
// Slave channel: one request per transfer. tuser carries the request kind and
// the camera, tdata the coordinates, the polarity and the stamp of a stamp
// request. Master channel: exactly one result per request, giving the
// addressed pixel value and time after the request, the newest left/right
// stamps and the two seen flags.
// A request's result is registered after the store read and the evaluate
// step; the next request is taken only after the evaluate step, so plain
// requests do not overlap, bound by the registered read of the pixel stores
// followed by the update write.
// Clear and time-reset requests sweep the affected stores one pixel a cycle,
// over all PIX_COUNT (16384) pixels, before the read.
// After reset the block sweeps every pixel of all four stores to zero with
// o_s_tready low; step_size returns to 127 and may be written at any time
// through i_cfg_wen / i_cfg_wdata while the block is idle.
// If the receiver stalls, the result is held in the output register; one
// more request is accepted and waits in its evaluate step until the held
// result has been taken.
module event_image_accumulator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // coord_a, coord_b, pol_on, stamp_in, zero pad
    input  logic [3:0]   i_s_tuser,   // req_type, cam_sel
    input  logic         i_cfg_wen,
    input  logic [6:0]   i_cfg_wdata, // step_size
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // pixel_value, pixel_time, newest_left, newest_right
    output logic [1:0]   o_m_tuser    // seen_left, seen_right
);

    eia_pkg::t_cmd cmd;
    logic          eval_ok;

    // Sequencer
    eia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req      (i_s_tuser[2:0]),
        .i_eval_ok  (eval_ok),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // Pixel stores, update arithmetic and result register
    eia_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_eval_ok   (eval_ok),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
